@@ rtl/core/spsc_pkg.sv @@
package spsc_pkg;

   // Bin counts of the spectrometer. Both are powers of two, so the modulo
   // reductions in the checker are plain bit selects.
   localparam int COARSE_BINS = 4096;
   localparam int FINE_BINS   = 32768;
   localparam int COARSE_W    = $clog2(COARSE_BINS);
   localparam int FINE_W      = $clog2(FINE_BINS);
   // One bit more than a coarse index holds the largest count of skipped bins.
   localparam int MISS_W      = COARSE_W + 1;

   localparam logic [31:0] LAST_VALID_BIN = 32'(COARSE_BINS - 1);
   localparam logic [31:0] HEADER_BYTES   = 32'd12;

   // Error code word fields.
   localparam logic [31:0] FFT_OVF_MASK  = 32'h2000_0000;
   localparam logic [31:0] PFB_OVF_MASK  = 32'h1000_0000;
   localparam logic [31:0] CT_ERR_MASK   = 32'h0F00_0000;
   localparam logic [31:0] FIFO_OVR_MASK = 32'h00FF_C000;

   // Register map.
   localparam int          CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SWAP_BYTES = 2'd0;

   // Place of the next word within a packet.
   typedef enum logic [2:0] {
      POS_LEN    = 3'd0,
      POS_SEC    = 3'd1,
      POS_USEC   = 3'd2,
      POS_COARSE = 3'd3,
      POS_MEAN   = 3'd4,
      POS_ERR    = 3'd5,
      POS_HBIN   = 3'd6,
      POS_HPWR   = 3'd7
   } pos_type;

   typedef enum logic [1:0] {
      KIND_BIN  = 2'd0,
      KIND_ERR  = 2'd1,
      KIND_HIT  = 2'd2
   } kind_type;

   // One result word.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] coarse_bin;
      logic [11:0] missing_now;
      logic        out_of_range;
      logic        spectrum_start;
      logic [3:0]  error_flags;
      logic [26:0] hit_fine_bin;
      logic [31:0] hit_power;
      logic [31:0] total_missing;
      logic [31:0] total_errors;
   } rsp_type;

endpackage

@@ rtl/core/spsc_csr.sv @@
module spsc_csr
   import spsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic                  swap_bytes
);

   logic swap_ff;
   logic swap_in;
   logic wr_en;

   // The access phase of a write to the swap register updates it.
   assign wr_en = psel && penable && pwrite && (paddr == ADDR_SWAP_BYTES);

   always_comb begin
      swap_in = swap_ff;
      if (wr_en) begin
         swap_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b0;
      end else begin
         swap_ff <= swap_in;
      end
   end

   // Read back; unmapped addresses read as zero.
   always_comb begin
      prdata = 32'd0;
      if (paddr == ADDR_SWAP_BYTES) begin
         prdata = {31'd0, swap_ff};
      end
   end

   assign pready     = 1'b1;
   assign swap_bytes = swap_ff;

endmodule

@@ rtl/core/spsc_core.sv @@
module spsc_core
   import spsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] word_in,
   input  logic        swap_bytes,
   output logic        emits,
   output rsp_type     rsp
);

   pos_type pos_ff, pos_in;
   logic [28:0]         hits_left_ff, hits_left_in;
   logic [31:0]         prev_bin_ff, prev_bin_in;
   logic                first_packet_ff, first_packet_in;
   logic                bin_valid_ff, bin_valid_in;
   logic [COARSE_W-1:0] rot_coarse_ff, rot_coarse_in;
   logic [FINE_W-1:0]   pend_fine_ff, pend_fine_in;
   logic [31:0]         miss_total_ff, miss_total_in;
   logic [31:0]         err_total_ff, err_total_in;

   logic [31:0]         w;
   logic                oor;
   logic                not_above;
   logic [MISS_W-1:0]   missing;
   logic [32:0]         miss_sum;
   logic [3:0]          flags;
   logic [2:0]          err_count;
   logic [32:0]         err_sum;
   logic [28:0]         hits_dec;

   function automatic logic [31:0] byte_reverse(input logic [31:0] v);
      byte_reverse = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // Packet data words may arrive byte swapped; the host header never is.
   always_comb begin
      w = word_in;
      if (swap_bytes && (pos_ff >= POS_COARSE)) begin
         w = byte_reverse(word_in);
      end
   end

   // Coarse bin continuity check.
   always_comb begin
      oor       = w > LAST_VALID_BIN;
      not_above = w <= prev_bin_ff;
      missing   = '0;
      if (!first_packet_ff && !oor) begin
         if (not_above) begin
            if ((prev_bin_ff <= LAST_VALID_BIN) &&
                !((w == 32'd0) && (prev_bin_ff == LAST_VALID_BIN))) begin
               missing = MISS_W'(LAST_VALID_BIN - prev_bin_ff + w);
            end
         end else if ((w - prev_bin_ff) != 32'd1) begin
            missing = MISS_W'(w - prev_bin_ff - 32'd1);
         end
      end
      miss_sum = {1'b0, miss_total_ff} + 33'(missing);
   end

   // Error field decode.
   always_comb begin
      flags[3]  = |(w & FFT_OVF_MASK);
      flags[2]  = |(w & PFB_OVF_MASK);
      flags[1]  = |(w & CT_ERR_MASK);
      flags[0]  = |(w & FIFO_OVR_MASK);
      err_count = 3'(flags[3]) + 3'(flags[2]) + 3'(flags[1]) + 3'(flags[0]);
      err_sum   = {1'b0, err_total_ff} + 33'(err_count);
   end

   assign hits_dec = (hits_left_ff == '0) ? '0 : hits_left_ff - 29'd1;

   // Next state and result for the word in hand.
   always_comb begin
      pos_in          = pos_ff;
      hits_left_in    = hits_left_ff;
      prev_bin_in     = prev_bin_ff;
      first_packet_in = first_packet_ff;
      bin_valid_in    = bin_valid_ff;
      rot_coarse_in   = rot_coarse_ff;
      pend_fine_in    = pend_fine_ff;
      miss_total_in   = miss_total_ff;
      err_total_in    = err_total_ff;
      emits           = 1'b0;
      rsp             = '0;

      case (pos_ff)
         POS_LEN: begin
            hits_left_in = (w < HEADER_BYTES) ? '0 : 29'((w - HEADER_BYTES) >> 3);
            pos_in       = POS_SEC;
         end
         POS_SEC: begin
            pos_in = POS_USEC;
         end
         POS_USEC: begin
            pos_in = POS_COARSE;
         end
         POS_COARSE: begin
            miss_total_in      = miss_sum[32] ? '1 : miss_sum[31:0];
            first_packet_in    = 1'b0;
            bin_valid_in       = 1'b1;
            prev_bin_in        = w;
            rot_coarse_in      = COARSE_W'(w[COARSE_W-1:0] + COARSE_W'(COARSE_BINS / 2));
            emits              = 1'b1;
            rsp.kind           = KIND_BIN;
            rsp.coarse_bin     = w;
            rsp.missing_now    = 12'(missing);
            rsp.out_of_range   = oor;
            rsp.spectrum_start = bin_valid_ff && not_above;
            rsp.total_missing  = miss_total_in;
            rsp.total_errors   = err_total_ff;
            pos_in             = POS_MEAN;
         end
         POS_MEAN: begin
            pos_in = POS_ERR;
         end
         POS_ERR: begin
            err_total_in      = err_sum[32] ? '1 : err_sum[31:0];
            emits             = 1'b1;
            rsp.kind          = KIND_ERR;
            rsp.coarse_bin    = prev_bin_ff;
            rsp.error_flags   = flags;
            rsp.total_missing = miss_total_ff;
            rsp.total_errors  = err_total_in;
            pos_in            = (hits_left_ff == '0) ? POS_LEN : POS_HBIN;
         end
         POS_HBIN: begin
            pend_fine_in = FINE_W'(w[FINE_W-1:0] + FINE_W'(FINE_BINS / 2));
            pos_in       = POS_HPWR;
         end
         default: begin
            emits             = 1'b1;
            rsp.kind          = KIND_HIT;
            rsp.coarse_bin    = prev_bin_ff;
            rsp.hit_fine_bin  = 27'(pend_fine_ff) + (27'(rot_coarse_ff) << FINE_W);
            rsp.hit_power     = w;
            rsp.total_missing = miss_total_ff;
            rsp.total_errors  = err_total_ff;
            hits_left_in      = hits_dec;
            pos_in            = (hits_dec == '0) ? POS_LEN : POS_HBIN;
         end
      endcase
   end

   // State registers advance only when the word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= POS_LEN;
         hits_left_ff    <= '0;
         prev_bin_ff     <= '0;
         first_packet_ff <= 1'b1;
         bin_valid_ff    <= 1'b0;
         rot_coarse_ff   <= '0;
         pend_fine_ff    <= '0;
         miss_total_ff   <= '0;
         err_total_ff    <= '0;
      end else if (go) begin
         pos_ff          <= pos_in;
         hits_left_ff    <= hits_left_in;
         prev_bin_ff     <= prev_bin_in;
         first_packet_ff <= first_packet_in;
         bin_valid_ff    <= bin_valid_in;
         rot_coarse_ff   <= rot_coarse_in;
         pend_fine_ff    <= pend_fine_in;
         miss_total_ff   <= miss_total_in;
         err_total_ff    <= err_total_in;
      end
   end

endmodule

@@ rtl/core/spectrometer_packet_stream_checker.sv @@
// Spectrometer packet stream checker.
// The req channel carries the recorded stream one 32-bit word at a time:
// length, seconds, microseconds, coarse bin, mean power, error code, then a
// bin word and a power word per hit. The rsp channel returns one word after
// each coarse bin word (bin check), each error code word (error flags) and
// each hit power word (hit record); other words give no result.
// The APB port holds swap_bytes at address 0, which byte swaps packet data.
// A taken word is held in the input register; its result is loaded into the
// rsp register when the word is processed, and rsp_valid rises with it.
// Throughput is one word per cycle while req_stall stays low, set by the
// combinational decode between the input register and the result register.
// While a result waits under rsp_stall the input register still accepts a
// word; words that give no result keep flowing, and req_stall rises only
// when the input register holds a word that needs the busy result register.
// Reset clears the packet position, running totals, the continuity history
// and swap_bytes, and empties both registers.
module spectrometer_packet_stream_checker
   import spsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [31:0]           req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [31:0]           rsp_coarse_bin,
   output logic [11:0]           rsp_missing_now,
   output logic                  rsp_out_of_range,
   output logic                  rsp_spectrum_start,
   output logic [3:0]            rsp_error_flags,
   output logic [26:0]           rsp_hit_fine_bin,
   output logic [31:0]           rsp_hit_power,
   output logic [31:0]           rsp_total_missing,
   output logic [31:0]           rsp_total_errors,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic        swap_bytes;
   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_word_ff, in_word_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        emits;
   logic        out_free;
   logic        go;
   logic        req_take;

   spsc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .swap_bytes (swap_bytes)
   );

   spsc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .word_in    (in_word_ff),
      .swap_bytes (swap_bytes),
      .emits      (emits),
      .rsp        (rsp_in)
   );

   // The held word is processed unless it needs a result slot that is full.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && (!emits || out_free);
   assign req_stall = in_valid_ff && !go;
   assign req_take  = req_valid && !req_stall;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go && emits) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      if (go && emits) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_coarse_bin     = rsp_ff.coarse_bin;
   assign rsp_missing_now    = rsp_ff.missing_now;
   assign rsp_out_of_range   = rsp_ff.out_of_range;
   assign rsp_spectrum_start = rsp_ff.spectrum_start;
   assign rsp_error_flags    = rsp_ff.error_flags;
   assign rsp_hit_fine_bin   = rsp_ff.hit_fine_bin;
   assign rsp_hit_power      = rsp_ff.hit_power;
   assign rsp_total_missing  = rsp_ff.total_missing;
   assign rsp_total_errors   = rsp_ff.total_errors;

   // A word held back in the input register must not be overwritten.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !go) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("input register lost a held word");

   // An out-of-range bin never counts skipped bins.
   a_oor_no_missing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_BIN) && rsp_out_of_range) |->
      (rsp_missing_now == 12'd0))
      else $error("missing bins counted for an out-of-range bin");

   // Hit fields stay zero outside hit records.
   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_HIT)) |->
      ((rsp_hit_fine_bin == 27'd0) && (rsp_hit_power == 32'd0)))
      else $error("hit fields set outside a hit record");

   // A new result is loaded only into a free slot.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !(go && emits))
      else $error("result register overwritten while stalled");

endmodule
